// File: rtl/core/irfc_pkg.sv
// Shared types and constants for the image rotate, flip and crop block.
// No dependencies; the top level and the checker import this package.
package irfc_pkg;

	// Largest image side; the store holds MAX_SIDE by MAX_SIDE pixels.
	localparam int MAX_SIDE = 64;
	localparam int SIDE_W   = $clog2(MAX_SIDE);
	localparam int ADDR_W   = 2 * SIDE_W;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int DIM_W    = 7;
	localparam int PIX_W    = 8;

	// Command codes.
	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_ROT    = 3'd3;
	localparam logic [2:0] OP_FLIPV  = 3'd4;
	localparam logic [2:0] OP_FLIPH  = 3'd5;
	localparam logic [2:0] OP_CROP   = 3'd6;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_CROP  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef struct packed {
		logic [2:0]        op;
		logic [5:0]        row;
		logic [5:0]        col;
		logic [7:0]        pixel_in;
		logic              rotate_right;
		logic signed [15:0] rotate_count;
		logic [6:0]        crop_left;
		logic [6:0]        crop_right;
		logic [6:0]        crop_top;
		logic [6:0]        crop_bottom;
	} cmd_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic [6:0] rows_now;
		logic [6:0] cols_now;
		logic [1:0] status;
	} result_t;

endpackage

// File: rtl/core/image_rotate_flip_crop.sv
// Top level of the image rotate, flip and crop block.
// Depends on irfc_pkg and instantiates irfc_ram twice (image and scratch).

// One command is taken when start is high and busy is low, and exactly one
// result follows, marked by done for a single cycle; it cannot be held off.
// A flip or crop runs two passes over the pixels at one pixel per cycle,
// limited by the single read port of each memory: the mapped copy from image
// to scratch and the copy back of the new image. A rotate repeats that per
// quarter turn, up to three times. Start, write, read, an unused code and a
// rejected command run no pass.
module image_rotate_flip_crop (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  irfc_pkg::cmd_t    cmd,
	output logic              done,
	output irfc_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [6:0]        cfg_wdata
);
	import irfc_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_P1   = 6'b000010,
		ST_D1   = 6'b000100,
		ST_P2   = 6'b001000,
		ST_D2   = 6'b010000,
		ST_RESP = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		MD_CW   = 3'b001,
		MD_CCW  = 3'b010,
		MD_VF   = 3'b011,
		MD_HF   = 3'b100,
		MD_COPY = 3'b101
	} mode_t;

	state_t state_q, acc_state;
	mode_t  mode_q, mode_act, acc_mode;
	logic [DIM_W-1:0]  cur_rows_q, cur_cols_q, cfg_rows_q, cfg_cols_q;
	logic [DIM_W-1:0]  nrows_q, ncols_q, acc_rows, acc_cols;
	logic [SIDE_W-1:0] r_q, c_q, r0_q, c0_q, r1_q, c1_q;
	logic [SIDE_W-1:0] acc_r0, acc_c0, acc_r1, acc_c1;
	logic [SIDE_W-1:0] dst_r, dst_c;
	logic [1:0] turns_q, status_q, acc_turns, acc_status;
	logic       rd_ok_q;
	logic       valid_s1, pass2_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic       accept, in_image, idle_wr, last, crop_ok;
	logic       img_we, scr_we;
	logic [ADDR_W-1:0] img_waddr, img_raddr, cnt_addr, cmd_addr;
	logic [PIX_W-1:0]  img_wdata, img_rdata, scr_rdata;
	logic [DIM_W-1:0]  lim_rows, lim_cols;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign cnt_addr = {r_q, c_q};
	assign cmd_addr = {cmd.row, cmd.col};
	assign in_image = ({1'b0, cmd.row} < cur_rows_q) && ({1'b0, cmd.col} < cur_cols_q);
	assign idle_wr  = accept && (cmd.op == OP_WRITE) && in_image;
	assign last     = (r_q == r1_q) && (c_q == c1_q);

	assign crop_ok = (cmd.crop_left != '0) && (cmd.crop_left <= cmd.crop_right) &&
	                 (cmd.crop_right <= cur_cols_q) && (cmd.crop_top != '0) &&
	                 (cmd.crop_top <= cmd.crop_bottom) && (cmd.crop_bottom <= cur_rows_q);

	// Start limits the configured sizes to 1..MAX_SIDE.
	always_comb begin
		lim_rows = cfg_rows_q;
		lim_cols = cfg_cols_q;
		if (cfg_rows_q == '0) lim_rows = DIM_W'(1);
		else if (cfg_rows_q > DIM_W'(MAX_SIDE)) lim_rows = DIM_W'(MAX_SIDE);
		if (cfg_cols_q == '0) lim_cols = DIM_W'(1);
		else if (cfg_cols_q > DIM_W'(MAX_SIDE)) lim_cols = DIM_W'(MAX_SIDE);
	end

	// Decode of a command at its transfer: status, next state and scan window.
	always_comb begin
		acc_state  = ST_RESP;
		acc_status = STAT_OK;
		acc_mode   = MD_COPY;
		acc_r0     = '0;
		acc_c0     = '0;
		acc_r1     = SIDE_W'(cur_rows_q - 1'b1);
		acc_c1     = SIDE_W'(cur_cols_q - 1'b1);
		acc_rows   = cur_rows_q;
		acc_cols   = cur_cols_q;
		acc_turns  = 2'd1;
		case (cmd.op)
			OP_WRITE, OP_READ: begin
				if (!in_image) acc_status = STAT_RANGE;
			end
			OP_ROT: begin
				acc_mode  = cmd.rotate_right ? MD_CW : MD_CCW;
				acc_turns = cmd.rotate_count[1:0];
				acc_rows  = cur_cols_q;
				acc_cols  = cur_rows_q;
				if (cmd.rotate_count[1:0] != 2'd0) acc_state = ST_P1;
			end
			OP_FLIPV: begin
				acc_mode  = MD_VF;
				acc_state = ST_P1;
			end
			OP_FLIPH: begin
				acc_mode  = MD_HF;
				acc_state = ST_P1;
			end
			OP_CROP: begin
				if (crop_ok) begin
					acc_r0    = SIDE_W'(cmd.crop_top - 1'b1);
					acc_c0    = SIDE_W'(cmd.crop_left - 1'b1);
					acc_r1    = SIDE_W'(cmd.crop_bottom - 1'b1);
					acc_c1    = SIDE_W'(cmd.crop_right - 1'b1);
					acc_rows  = cmd.crop_bottom - cmd.crop_top + 1'b1;
					acc_cols  = cmd.crop_right - cmd.crop_left + 1'b1;
					acc_state = ST_P1;
				end else begin
					acc_status = STAT_CROP;
				end
			end
			default: begin
				acc_status = STAT_OK;
			end
		endcase
	end

	// Destination of the pixel at the counter; the second pass copies in place.
	always_comb begin
		mode_act = (state_q == ST_P2) ? MD_COPY : mode_q;
		dst_r    = r_q - r0_q;
		dst_c    = c_q - c0_q;
		unique case (mode_act)
			MD_CW: begin
				dst_r = c_q;
				dst_c = r1_q - r_q;
			end
			MD_CCW: begin
				dst_r = c1_q - c_q;
				dst_c = r_q;
			end
			MD_VF: begin
				dst_r = r1_q - r_q;
				dst_c = c_q;
			end
			MD_HF: begin
				dst_r = r_q;
				dst_c = c1_q - c_q;
			end
			default: begin
				dst_r = r_q - r0_q;
				dst_c = c_q - c0_q;
			end
		endcase
	end

	// Memory port steering.
	assign img_raddr = (state_q == ST_P1) ? cnt_addr : cmd_addr;
	assign img_we    = idle_wr || (valid_s1 && pass2_s1);
	assign img_waddr = idle_wr ? cmd_addr : dst_s1;
	assign img_wdata = idle_wr ? cmd.pixel_in : scr_rdata;
	assign scr_we    = valid_s1 && !pass2_s1;

	irfc_ram #(.DEPTH(CELLS), .WIDTH(PIX_W)) u_image (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (img_wdata),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	irfc_ram #(.DEPTH(CELLS), .WIDTH(PIX_W)) u_scratch (
		.clk   (clk),
		.we    (scr_we),
		.waddr (dst_s1),
		.wdata (img_rdata),
		.raddr (cnt_addr),
		.rdata (scr_rdata)
	);

	// Write-back stage: the pixel read this cycle lands at its destination next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pass2_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_P1) || (state_q == ST_P2);
			pass2_s1 <= (state_q == ST_P2);
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= {dst_r, dst_c};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_rows_q <= DIM_W'(64);
			cfg_cols_q <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS: cfg_rows_q <= cfg_wdata;
				CFG_COLS: cfg_cols_q <= cfg_wdata;
				default:  cfg_rows_q <= cfg_rows_q;
			endcase
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MD_COPY;
			cur_rows_q <= DIM_W'(MAX_SIDE);
			cur_cols_q <= DIM_W'(MAX_SIDE);
			nrows_q    <= '0;
			ncols_q    <= '0;
			r_q        <= '0;
			c_q        <= '0;
			r0_q       <= '0;
			c0_q       <= '0;
			r1_q       <= '0;
			c1_q       <= '0;
			turns_q    <= '0;
			status_q   <= STAT_OK;
			rd_ok_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						status_q <= acc_status;
						rd_ok_q  <= (cmd.op == OP_READ) && in_image;
						state_q  <= acc_state;
						mode_q   <= acc_mode;
						r0_q     <= acc_r0;
						c0_q     <= acc_c0;
						r_q      <= acc_r0;
						c_q      <= acc_c0;
						r1_q     <= acc_r1;
						c1_q     <= acc_c1;
						nrows_q  <= acc_rows;
						ncols_q  <= acc_cols;
						turns_q  <= acc_turns;
						if (cmd.op == OP_START) begin
							cur_rows_q <= lim_rows;
							cur_cols_q <= lim_cols;
						end
					end
				end
				ST_P1, ST_P2: begin
					if (last) begin
						state_q <= (state_q == ST_P1) ? ST_D1 : ST_D2;
					end else if (c_q == c1_q) begin
						c_q <= c0_q;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_D1: begin
					// Copy the new image back from scratch.
					r0_q    <= '0;
					c0_q    <= '0;
					r_q     <= '0;
					c_q     <= '0;
					r1_q    <= SIDE_W'(nrows_q - 1'b1);
					c1_q    <= SIDE_W'(ncols_q - 1'b1);
					state_q <= ST_P2;
				end
				ST_D2: begin
					cur_rows_q <= nrows_q;
					cur_cols_q <= ncols_q;
					if (turns_q > 2'd1) begin
						// Another quarter turn on the image just committed.
						turns_q <= turns_q - 1'b1;
						r_q     <= '0;
						c_q     <= '0;
						r1_q    <= SIDE_W'(nrows_q - 1'b1);
						c1_q    <= SIDE_W'(ncols_q - 1'b1);
						nrows_q <= ncols_q;
						ncols_q <= nrows_q;
						state_q <= ST_P1;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result transfer; the read data arrives in the response cycle.
	assign done             = (state_q == ST_RESP);
	assign result.pixel_out = rd_ok_q ? img_rdata : '0;
	assign result.rows_now  = cur_rows_q;
	assign result.cols_now  = cur_cols_q;
	assign result.status    = status_q;

endmodule

// File: rtl/core/irfc_ram.sv
// Simple dual-port pixel memory: one write port, one registered read port.
// Depends on nothing but its parameters.
module irfc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read share the clock.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/irfc_checker.sv
// Port-level checks for the image rotate, flip and crop block, and the bind
// that attaches them to the top level. Depends on irfc_pkg.
module irfc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input irfc_pkg::result_t result
);
	import irfc_pkg::*;

	// An accepted command makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after a command transfer");

	// A result transfer ends the command.
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done)
		else $error("block still busy after its result transfer");

	// Results only appear while a command is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result transfer without a command");

	// A flagged command never returns pixel data.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != STAT_OK) |-> result.pixel_out == '0)
		else $error("pixel data on a flagged result");

	// Image size stays within the store.
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.rows_now != '0) && (result.rows_now <= 7'(MAX_SIDE)) &&
		         (result.cols_now != '0) && (result.cols_now <= 7'(MAX_SIDE)))
		else $error("image size out of range");

endmodule

bind image_rotate_flip_crop irfc_checker u_irfc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
